### design/circle_masked_histogram_top_assert.svh
// Assertion macros for the circle masked histogram.
// Used by the port checker; no other dependencies.
`ifndef CIRCLE_MASKED_HISTOGRAM_TOP_ASSERT_SVH
`define CIRCLE_MASKED_HISTOGRAM_TOP_ASSERT_SVH

// same-cycle implication
`define CMH_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/cmh_pkg.sv
// Package for the circle masked histogram: widths, codes, transfer structs.
// No dependencies.
`default_nettype none

package cmh_pkg;

  localparam int BINS      = 256;
  localparam int MAX_DIM   = 1024;
  localparam int FRAC_BITS = 16;

  localparam int PIX_W   = 8;
  localparam int IDX_W   = 8;
  localparam int FUNC_W  = 2;
  localparam int BIN_W   = $clog2(BINS);
  localparam int COORD_W = $clog2(MAX_DIM);
  localparam int DIM_W   = COORD_W + 1;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int COUNT_W = 21;
  localparam int PCT_W   = 23;

  localparam int PCT_SCALE = 100;
  localparam int SCALE_W   = 7;
  localparam int PROD_W    = COUNT_W + SCALE_W;
  localparam int NUM_W     = PROD_W + FRAC_BITS;
  localparam int DEN_W     = 2 * DIM_W;
  localparam int CMP_W     = (NUM_W > DEN_W + PCT_W) ? NUM_W : DEN_W + PCT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [PCT_W-1:0]   PCT_MAX   = {PCT_W{1'b1}};

  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = DIM_W;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_COL   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_ROW   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS       = 3'd4;

  localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = DIM_W'(512);
  localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = DIM_W'(512);
  localparam logic [COORD_W-1:0] RST_CENTER_COL   = COORD_W'(256);
  localparam logic [COORD_W-1:0] RST_CENTER_ROW   = COORD_W'(256);
  localparam logic [COORD_W-1:0] RST_RADIUS       = COORD_W'(256);

  localparam logic [FUNC_W-1:0] FUNC_ACCUM = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  typedef struct packed {
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [COORD_W-1:0] center_col;
    logic [COORD_W-1:0] center_row;
    logic [COORD_W-1:0] radius;
  } cmh_cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [PIX_W-1:0]   pixel_value;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [IDX_W-1:0]   bin_index;
  } cmh_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic [PCT_W-1:0]   percent_fixed;
  } cmh_out_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic               clr;
    logic [BIN_W-1:0]   addr;
    logic [COUNT_W-1:0] wdata;
  } cmh_mem_req_t;

  function automatic logic [BIN_W-1:0] bin_of(input logic [PIX_W-1:0] pix);
    logic [PIX_W+BIN_W:0] prod;
    prod = (PIX_W+BIN_W+1)'(pix) * (PIX_W+BIN_W+1)'(BINS);
    return BIN_W'(prod >> PIX_W);
  endfunction

endpackage

`default_nettype wire

### design/cmh_store.sv
// Bin count memory: one port, registered read, per-bin valid flags for clear.
// Depends on cmh_pkg.
`default_nettype none

module cmh_store (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cmh_pkg::cmh_mem_req_t        req_i,
  output logic [cmh_pkg::COUNT_W-1:0]       rd_data_o
);

  logic [cmh_pkg::COUNT_W-1:0] mem_q [cmh_pkg::BINS];
  logic [cmh_pkg::BINS-1:0]    vld_q;
  logic [cmh_pkg::COUNT_W-1:0] rd_data_q;
  logic                        rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

`default_nettype wire

### design/cmh_mask.sv
// Circle membership test: squared distance against squared radius, two stages.
// Depends on cmh_pkg.
`default_nettype none

module cmh_mask (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [cmh_pkg::COORD_W-1:0]   col_i,
  input  wire logic [cmh_pkg::COORD_W-1:0]   row_i,
  input  wire cmh_pkg::cmh_cfg_t             cfg_i,
  output logic                               done_o,
  output logic                               inside_o
);

  logic [cmh_pkg::COORD_W-1:0] dx, dy;
  logic [cmh_pkg::SQ_W-1:0]    dxx_q, dyy_q, rr_q;
  logic [cmh_pkg::SQ_W:0]      dist_sq;
  logic                        v1_q, done_q, inside_q;

  assign dx = (col_i >= cfg_i.center_col) ? col_i - cfg_i.center_col
                                          : cfg_i.center_col - col_i;
  assign dy = (row_i >= cfg_i.center_row) ? row_i - cfg_i.center_row
                                          : cfg_i.center_row - row_i;

  assign dist_sq = (cmh_pkg::SQ_W+1)'(dxx_q) + (cmh_pkg::SQ_W+1)'(dyy_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dxx_q <= cmh_pkg::SQ_W'(dx) * cmh_pkg::SQ_W'(dx);
      dyy_q <= cmh_pkg::SQ_W'(dy) * cmh_pkg::SQ_W'(dy);
      rr_q  <= cmh_pkg::SQ_W'(cfg_i.radius) * cmh_pkg::SQ_W'(cfg_i.radius);
    end
    if (v1_q) begin
      inside_q <= dist_sq <= (cmh_pkg::SQ_W+1)'(rr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      done_q <= v1_q;
    end
  end

  assign done_o   = done_q;
  assign inside_o = inside_q;

endmodule

`default_nettype wire

### design/cmh_div.sv
// Bit-serial restoring divider for the percentage, saturating, zero on zero divisor.
// Depends on cmh_pkg.
`default_nettype none

module cmh_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [cmh_pkg::NUM_W-1:0]   num_i,
  input  wire logic [cmh_pkg::DEN_W-1:0]   den_i,
  output logic                             done_o,
  output logic [cmh_pkg::PCT_W-1:0]        quo_o
);

  localparam int CNT_W = $clog2(cmh_pkg::PCT_W + 1);

  logic [cmh_pkg::DEN_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [cmh_pkg::PCT_W-1:0] nsh_q, nsh_d, quo_q, quo_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      busy_q, busy_d, done_q, done_d;
  logic [cmh_pkg::DEN_W:0]   trial;
  logic                      ge, ovf;

  assign trial = {rem_q, nsh_q[cmh_pkg::PCT_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign ovf   = cmh_pkg::CMP_W'(num_i) >=
                 (cmh_pkg::CMP_W'(den_i) << cmh_pkg::PCT_W);

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    nsh_d  = nsh_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      if (den_i == '0) begin
        quo_d  = '0;
        done_d = 1'b1;
      end else if (ovf) begin
        quo_d  = cmh_pkg::PCT_MAX;
        done_d = 1'b1;
      end else begin
        rem_d  = cmh_pkg::DEN_W'(num_i >> cmh_pkg::PCT_W);
        nsh_d  = num_i[cmh_pkg::PCT_W-1:0];
        den_d  = den_i;
        quo_d  = '0;
        cnt_d  = CNT_W'(cmh_pkg::PCT_W);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? cmh_pkg::DEN_W'(trial - {1'b0, den_q}) : cmh_pkg::DEN_W'(trial);
      quo_d = {quo_q[cmh_pkg::PCT_W-2:0], ge};
      nsh_d = nsh_q << 1;
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    nsh_q <= nsh_d;
    quo_q <= quo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

### design/circle_masked_histogram_top.sv
// Circle masked intensity histogram: one item at a time. An accumulate item
// runs the registered distance test and, only when the pixel lies inside the
// circle, the bin memory read and the write back. For a clear item the bins
// read as zero at once through per-bin valid flags, and no clearing pass
// follows reset. A read item runs the memory read and then the 23-step
// bit-serial divider. A finished result sits in an output register, so the
// next item is accepted while it waits to be taken.
// Depends on cmh_pkg, cmh_store, cmh_mask, cmh_div.
`default_nettype none

module circle_masked_histogram_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cmh_pkg::REG_IDX_W-1:0]   cfg_addr_i,
  input  wire logic [cmh_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire cmh_pkg::cmh_in_t                in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output cmh_pkg::cmh_out_t                    out_data_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MASK = 7'b0000010,
    ST_UPD  = 7'b0000100,
    ST_RD   = 7'b0001000,
    ST_DGO  = 7'b0010000,
    ST_DIVW = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  state_e                         state_q, state_d;
  cmh_pkg::cmh_cfg_t              cfg_q;
  cmh_pkg::cmh_mem_req_t          mem_req;
  logic [cmh_pkg::COUNT_W-1:0]    rd_data;
  logic [cmh_pkg::BIN_W-1:0]      bin_q;
  logic                           idx_ok, idx_ok_q;
  logic [cmh_pkg::COUNT_W-1:0]    cnt, cnt_q;
  logic [cmh_pkg::PROD_W-1:0]     prod_q;
  logic [cmh_pkg::DEN_W-1:0]      tot_q;
  logic                           in_accept, mask_start, mask_done, hit;
  logic                           div_start, div_done, out_load, out_valid_q;
  logic [cmh_pkg::PCT_W-1:0]      quo;
  cmh_pkg::cmh_out_t              out_data_q;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != ST_IDLE;
  assign idx_ok = (cmh_pkg::IDX_W+1)'(in_data_i.bin_index) <
                  (cmh_pkg::IDX_W+1)'(cmh_pkg::BINS);
  assign cnt = idx_ok_q ? rd_data : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= cmh_pkg::RST_IMAGE_WIDTH;
      cfg_q.image_height <= cmh_pkg::RST_IMAGE_HEIGHT;
      cfg_q.center_col   <= cmh_pkg::RST_CENTER_COL;
      cfg_q.center_row   <= cmh_pkg::RST_CENTER_ROW;
      cfg_q.radius       <= cmh_pkg::RST_RADIUS;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        cmh_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_wdata_i;
        cmh_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_wdata_i;
        cmh_pkg::REG_CENTER_COL:   cfg_q.center_col   <= cmh_pkg::COORD_W'(cfg_wdata_i);
        cmh_pkg::REG_CENTER_ROW:   cfg_q.center_row   <= cmh_pkg::COORD_W'(cfg_wdata_i);
        cmh_pkg::REG_RADIUS:       cfg_q.radius       <= cmh_pkg::COORD_W'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    mem_req    = '0;
    mask_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_data_i.func)
            cmh_pkg::FUNC_ACCUM: begin
              mask_start = 1'b1;
              state_d    = ST_MASK;
            end
            cmh_pkg::FUNC_READ: begin
              mem_req.rd_en = idx_ok;
              mem_req.addr  = cmh_pkg::BIN_W'(in_data_i.bin_index);
              state_d       = ST_RD;
            end
            cmh_pkg::FUNC_CLEAR: mem_req.clr = 1'b1;
            default: ;
          endcase
        end
      end
      ST_MASK: begin
        if (mask_done) begin
          if (hit) begin
            mem_req.rd_en = 1'b1;
            mem_req.addr  = bin_q;
            state_d       = ST_UPD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_UPD: begin
        mem_req.wr_en = 1'b1;
        mem_req.addr  = bin_q;
        mem_req.wdata = (rd_data == cmh_pkg::COUNT_MAX) ? rd_data
                                                        : rd_data + cmh_pkg::COUNT_W'(1);
        state_d       = ST_IDLE;
      end
      ST_RD:   state_d = ST_DGO;
      ST_DGO: begin
        div_start = 1'b1;
        state_d   = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      bin_q    <= cmh_pkg::bin_of(in_data_i.pixel_value);
      idx_ok_q <= idx_ok;
    end
    if (state_q == ST_RD) begin
      cnt_q  <= cnt;
      prod_q <= cmh_pkg::PROD_W'(cnt) * cmh_pkg::PROD_W'(cmh_pkg::PCT_SCALE);
      tot_q  <= cmh_pkg::DEN_W'(cfg_q.image_width) * cmh_pkg::DEN_W'(cfg_q.image_height);
    end
    if (out_load) begin
      out_data_q.bin_count     <= cnt_q;
      out_data_q.percent_fixed <= quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  cmh_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  cmh_mask u_mask (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mask_start),
    .col_i    (in_data_i.col),
    .row_i    (in_data_i.row),
    .cfg_i    (cfg_q),
    .done_o   (mask_done),
    .inside_o (hit)
  );

  cmh_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (cmh_pkg::NUM_W'(prod_q) << cmh_pkg::FRAC_BITS),
    .den_i   (tot_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

### design/cmh_checker.sv
// Port-level checker for the circle masked histogram, bound to the top level.
// Depends on cmh_pkg and circle_masked_histogram_top_assert.svh.
`default_nettype none

`include "circle_masked_histogram_top_assert.svh"

module cmh_checker (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [cmh_pkg::REG_IDX_W-1:0]   cfg_addr_i,
  input  wire logic [cmh_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_stall_o,
  input  wire cmh_pkg::cmh_in_t                in_data_i,
  input  wire logic                            out_valid_o,
  input  wire logic                            out_stall_i,
  input  wire cmh_pkg::cmh_out_t               out_data_o
);

  logic in_xfer, cfg_seen;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign cfg_seen = cfg_we_i && (cfg_addr_i == cmh_pkg::REG_RADIUS) && (cfg_wdata_i == '0);

  `CMH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o), "stalled result changed")

  `CMH_ASSERT_SAME(a_zero_pct, clk_i, rst_ni, out_valid_o && (out_data_o.bin_count == '0),
    out_data_o.percent_fixed == '0, "nonzero percentage for empty bin")

  `CMH_ASSERT_NEXT(a_busy_after, clk_i, rst_ni,
    in_xfer && !cfg_seen && ((in_data_i.func == cmh_pkg::FUNC_ACCUM) ||
    (in_data_i.func == cmh_pkg::FUNC_READ)), in_stall_o, "no busy after accumulate or read")

  `CMH_ASSERT_SAME(a_result_source, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o),
    "result appeared without a read in flight")

endmodule

bind circle_masked_histogram_top cmh_checker u_checker (.*);

`default_nettype wire
